[rtl/core/sbd_pkg.sv]
// Package for shadow_bias_derivation: field widths, default fraction width
// and the side-band payload carried down the pipeline. No dependencies.
package sbd_pkg;

   localparam int FRAC_BITS_DEF = 16;

   localparam int TEXEL_W  = 24;
   localparam int COS_W    = 18;
   localparam int ERR_W    = 24;
   localparam int CBIAS_W  = 23;
   localparam int SLOPE_W  = 26;
   localparam int OFFS_W   = 24;
   localparam int MAG_W    = 23;

   typedef struct packed {
      logic [MAG_W-1:0]   texel;
      logic [CBIAS_W-1:0] cbias;
      logic [OFFS_W-1:0]  offs;
   } side_type;

endpackage

[rtl/core/shadow_bias_derivation.sv]
// Top level of shadow_bias_derivation: slope-scaled shadow depth bias pipeline.
// Depends on sbd_pkg.
//
//   channel | ports                                          | direction
//   req     | req_valid, req_stall, req_texel_size, req_light_cosine,
//           | req_geometry_error, req_plane_depth_on         | in
//   rsp     | rsp_valid, rsp_stall, rsp_constant_bias, rsp_slope_bias,
//           | rsp_offset_bias                                | out
//
// One transfer per cycle in, one per cycle out, while the output is not stalled.
// Stages: clamp, square, remainder, FRAC_BITS+1 square-root bit stages, one
// divide setup stage, FRAC_BITS+8 quotient bit stages, cap, multiply, output.
// Reset clears all valid bits. A stall on the held output freezes every stage.
module shadow_bias_derivation
   import sbd_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [TEXEL_W-1:0] req_texel_size,
   input  logic signed [COS_W-1:0]   req_light_cosine,
   input  logic signed [ERR_W-1:0]   req_geometry_error,
   input  logic                      req_plane_depth_on,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [CBIAS_W-1:0]        rsp_constant_bias,
   output logic [SLOPE_W-1:0]        rsp_slope_bias,
   output logic [OFFS_W-1:0]         rsp_offset_bias
);

   localparam int F   = FRAC_BITS;
   localparam int CW  = F + 1;
   localparam int RW  = F + 1;
   localparam int XW  = 2 * RW;
   localparam int SRW = RW + 2;
   localparam int QW  = F + 8;
   localparam int DRW = F + 2;
   localparam int TW  = F + 4;
   localparam int PW  = MAG_W + TW;
   localparam logic [31:0] ONE32  = 32'(1) << F;
   localparam logic [31:0] CMIN32 = ONE32 / 100;
   localparam logic [CW-1:0] ONE_C = CW'(ONE32);
   localparam logic [QW-1:0] CAP_Q = QW'(8) << F;

   logic rsp_valid_ff;
   logic adv;
   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;

   // clamp
   logic              v0_ff;
   side_type          sd0_ff;
   logic [CW-1:0]     c0_ff;
   logic [MAG_W-1:0]  tx_in, er_in;
   logic [31:0]       cr_in;
   logic [CW-1:0]     c0_in;

   always_comb begin
      tx_in = req_texel_size[TEXEL_W-1] ? '0 : req_texel_size[MAG_W-1:0];
      er_in = req_geometry_error[ERR_W-1] ? '0 : req_geometry_error[MAG_W-1:0];
      cr_in = req_light_cosine[COS_W-1] ? '0 : 32'(req_light_cosine[COS_W-2:0]);
      if (cr_in < CMIN32) begin
         c0_in = CW'(CMIN32);
      end else if (cr_in > ONE32) begin
         c0_in = ONE_C;
      end else begin
         c0_in = CW'(cr_in);
      end
   end

   logic v1_ff;
   side_type sd1_ff;
   logic [CW-1:0] c1_ff;
   logic [2*CW-1:0] csq1_ff;

   logic [RW:0][SRW-1:0] sq_rem_ff;
   logic [RW:0][RW-1:0]  sq_root_ff;
   logic [RW:0][XW-1:0]  sq_x_ff;
   logic [RW:0][CW-1:0]  sq_c_ff;
   logic [RW:0]          sq_v_ff;
   side_type [RW:0]      sq_sd_ff;

   logic [2*CW-1:0] c2_full;
   logic [CW-1:0]   rem_in;
   assign c2_full = csq1_ff >> F;
   assign rem_in  = (c2_full < (2*CW)'(ONE_C)) ? (ONE_C - CW'(c2_full)) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff      <= 1'b0;
         v1_ff      <= 1'b0;
         sq_v_ff[0] <= 1'b0;
      end else if (adv) begin
         v0_ff      <= req_valid;
         v1_ff      <= v0_ff;
         sq_v_ff[0] <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sd0_ff.texel    <= tx_in;
         sd0_ff.cbias    <= req_plane_depth_on ? (tx_in >> 2) : tx_in;
         sd0_ff.offs     <= OFFS_W'(tx_in >> 1) + OFFS_W'(er_in);
         c0_ff           <= c0_in;
         sd1_ff          <= sd0_ff;
         c1_ff           <= c0_ff;
         csq1_ff         <= c0_ff * c0_ff;
         sq_sd_ff[0]     <= sd1_ff;
         sq_c_ff[0]      <= c1_ff;
         sq_rem_ff[0]    <= '0;
         sq_root_ff[0]   <= '0;
         sq_x_ff[0]      <= XW'({rem_in, F'(0)});
      end
   end

   // square root, one result bit per stage
   for (genvar i = 0; i < RW; i++) begin : g_sqrt
      logic [SRW-1:0] pr, trial, rem_n;
      logic [RW-1:0]  root_n;
      always_comb begin
         pr    = {sq_rem_ff[i][SRW-3:0], sq_x_ff[i][XW-1:XW-2]};
         trial = {sq_root_ff[i], 2'b01};
         if (pr >= trial) begin
            rem_n  = pr - trial;
            root_n = {sq_root_ff[i][RW-2:0], 1'b1};
         end else begin
            rem_n  = pr;
            root_n = {sq_root_ff[i][RW-2:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            sq_v_ff[i+1] <= 1'b0;
         end else if (adv) begin
            sq_v_ff[i+1] <= sq_v_ff[i];
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            sq_rem_ff[i+1]  <= rem_n;
            sq_root_ff[i+1] <= root_n;
            sq_x_ff[i+1]    <= sq_x_ff[i] << 2;
            sq_c_ff[i+1]    <= sq_c_ff[i];
            sq_sd_ff[i+1]   <= sq_sd_ff[i];
         end
      end
   end

   // divide (s << F) / c, one quotient bit per stage
   logic [QW:0][DRW-1:0] dv_rem_ff;
   logic [QW:0][QW-1:0]  dv_q_ff;
   logic [QW:0][QW-1:0]  dv_n_ff;
   logic [QW:0][CW-1:0]  dv_c_ff;
   logic [QW:0]          dv_v_ff;
   side_type [QW:0]      dv_sd_ff;
   logic [RW-1:0]        s_root;
   assign s_root = sq_root_ff[RW];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_v_ff[0] <= 1'b0;
      end else if (adv) begin
         dv_v_ff[0] <= sq_v_ff[RW];
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         dv_rem_ff[0] <= DRW'(s_root >> 8);
         dv_q_ff[0]   <= '0;
         dv_n_ff[0]   <= {s_root[7:0], F'(0)};
         dv_c_ff[0]   <= sq_c_ff[RW];
         dv_sd_ff[0]  <= sq_sd_ff[RW];
      end
   end

   for (genvar j = 0; j < QW; j++) begin : g_div
      logic [DRW-1:0] pr, rem_n;
      logic           qb;
      always_comb begin
         pr = {dv_rem_ff[j][DRW-2:0], dv_n_ff[j][QW-1]};
         qb = (pr >= DRW'(dv_c_ff[j]));
         rem_n = qb ? (pr - DRW'(dv_c_ff[j])) : pr;
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[j+1] <= 1'b0;
         end else if (adv) begin
            dv_v_ff[j+1] <= dv_v_ff[j];
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            dv_rem_ff[j+1] <= rem_n;
            dv_q_ff[j+1]   <= {dv_q_ff[j][QW-2:0], qb};
            dv_n_ff[j+1]   <= dv_n_ff[j] << 1;
            dv_c_ff[j+1]   <= dv_c_ff[j];
            dv_sd_ff[j+1]  <= dv_sd_ff[j];
         end
      end
   end

   // cap, multiply, output
   logic          vcap_ff, vmul_ff;
   logic [TW-1:0] tan_ff;
   side_type      sdc_ff, sdm_ff;
   logic [PW-1:0] prod_ff;
   logic [CBIAS_W-1:0] cbias_ff;
   logic [SLOPE_W-1:0] slope_ff;
   logic [OFFS_W-1:0]  offs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vcap_ff      <= 1'b0;
         vmul_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vcap_ff      <= dv_v_ff[QW];
         vmul_ff      <= vcap_ff;
         rsp_valid_ff <= vmul_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tan_ff   <= (dv_q_ff[QW] > CAP_Q) ? TW'(CAP_Q) : dv_q_ff[QW][TW-1:0];
         sdc_ff   <= dv_sd_ff[QW];
         prod_ff  <= PW'(sdc_ff.texel) * PW'(tan_ff);
         sdm_ff   <= sdc_ff;
         cbias_ff <= sdm_ff.cbias;
         slope_ff <= prod_ff[F+SLOPE_W-1:F];
         offs_ff  <= sdm_ff.offs;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_constant_bias = cbias_ff;
   assign rsp_slope_bias    = slope_ff;
   assign rsp_offset_bias   = offs_ff;

endmodule

[sim/tb_top.sv]
// Testbench for shadow_bias_derivation: directed table then random transfers,
// each checked against table values or a behavioral bias calculator. Depends on sbd_pkg.
`timescale 1ns / 1ps

module tb_top
   import sbd_pkg::*;
();

   localparam int FB      = FRAC_BITS_DEF;
   localparam int LAT     = 2 * FB + 16;
   localparam int WDOG    = 20000;
   localparam int N_RAND  = 1430;
   localparam longint ONE = 64'd1 << FB;

   typedef struct {
      logic [CBIAS_W-1:0] cbias;
      logic [SLOPE_W-1:0] slope;
      logic [OFFS_W-1:0]  offs;
   } bias_type;

   typedef struct {
      logic [TEXEL_W-1:0] texel;
      logic [COS_W-1:0]   cosv;
      logic [ERR_W-1:0]   err;
      logic               plane;
      bit                 typed;
      bias_type           want;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [TEXEL_W-1:0] req_texel_size = '0;
   logic signed [COS_W-1:0]   req_light_cosine = '0;
   logic signed [ERR_W-1:0]   req_geometry_error = '0;
   logic req_plane_depth_on = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [CBIAS_W-1:0] rsp_constant_bias;
   logic [SLOPE_W-1:0] rsp_slope_bias;
   logic [OFFS_W-1:0]  rsp_offset_bias;

   bias_type pending_bias[$];
   int    mismatches = 0;
   int    results_seen = 0;
   int    sent = 0;
   int    idle_cnt = 0;
   bit    calm = 1'b0;
   bit    done = 1'b0;

   shadow_bias_derivation DUT (.*);

   always #6 clock = ~clock;

   function automatic longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic bias_type calc_bias(logic [TEXEL_W-1:0] t, logic [COS_W-1:0] c,
                                          logic [ERR_W-1:0] e, logic p);
      longint unsigned tx, cs, er, c2, rem, s, tn;
      bias_type b;
      tx = t[TEXEL_W-1] ? 0 : t;
      cs = c[COS_W-1] ? 0 : c;
      er = e[ERR_W-1] ? 0 : e;
      if (cs < ONE / 100) cs = ONE / 100;
      if (cs > ONE) cs = ONE;
      c2 = (cs * cs) >> FB;
      rem = (c2 < ONE) ? ONE - c2 : 0;
      s = floor_sqrt(rem << FB);
      tn = (s << FB) / cs;
      if (tn > 8 * ONE) tn = 8 * ONE;
      b.cbias = p ? tx >> 2 : tx;
      b.slope = (tx * tn) >> FB;
      b.offs = (tx >> 1) + er;
      return b;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s at result %0d: got %0d want %0d", what, results_seen, got, want);
      mismatches++;
   endtask

   function automatic bit idle_now();
      return !calm && ($urandom_range(99) < 31);
   endfunction

   // response side: random stall, check each transfer
   always @(posedge clock) begin
      bias_type w;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_bias.size() == 0) begin
               report_mismatch("unexpected result", rsp_slope_bias, 0);
            end else begin
               w = pending_bias.pop_front();
               if (rsp_constant_bias !== w.cbias)
                  report_mismatch("constant_bias", rsp_constant_bias, w.cbias);
               if (rsp_slope_bias !== w.slope)
                  report_mismatch("slope_bias", rsp_slope_bias, w.slope);
               if (rsp_offset_bias !== w.offs)
                  report_mismatch("offset_bias", rsp_offset_bias, w.offs);
            end
            results_seen++;
         end
         rsp_stall <= idle_now();
      end
   end

   // watchdog on cycles with no transfer
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cnt <= 0;
      else idle_cnt <= idle_cnt + 1;
      if (!done && idle_cnt > WDOG) begin
         $display("watchdog expired");
         $display("FAIL");
         $finish;
      end
   end

   task automatic send(row_type r);
      while (idle_now()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_texel_size <= r.texel;
      req_light_cosine <= r.cosv;
      req_geometry_error <= r.err;
      req_plane_depth_on <= r.plane;
      do @(posedge clock); while (req_stall);
      pending_bias.push_back(r.typed ? r.want :
                             calc_bias(r.texel, r.cosv, r.err, r.plane));
      sent++;
   endtask

   function automatic row_type mk(longint t, longint c, longint e, bit p,
                                  bit typed = 0, longint cb = 0, longint sl = 0,
                                  longint of = 0);
      row_type r;
      r.texel = t; r.cosv = c; r.err = e; r.plane = p; r.typed = typed;
      r.want.cbias = cb; r.want.slope = sl; r.want.offs = of;
      return r;
   endfunction

   initial begin
      row_type dir[$];
      row_type r;
      int k;
      // zeros, negative clamps, cosine extremes, grazing cap, quarter term
      dir.push_back(mk(0, 0, 0, 0, 1, 0, 0, 0));
      dir.push_back(mk(-1, 65536, -1, 0, 1, 0, 0, 0));
      dir.push_back(mk(-8388608, -131072, -8388608, 1, 1, 0, 0, 0));
      dir.push_back(mk(65536, 65536, 0, 0, 1, 65536, 0, 32768));
      dir.push_back(mk(65536, 131071, 65536, 1, 1, 16384, 0, 98304));
      dir.push_back(mk(65536, 0, 0, 0, 1, 65536, 524288, 32768));
      dir.push_back(mk(65536, -5, 0, 0, 1, 65536, 524288, 32768));
      dir.push_back(mk(65536, 654, 0, 1, 1, 16384, 524288, 32768));
      dir.push_back(mk(8388607, 655, 8388607, 0));
      dir.push_back(mk(8388607, 8000, 8388607, 1));
      dir.push_back(mk(8388607, 65535, 0, 0));
      dir.push_back(mk(8388607, 65537, 0, 1));
      dir.push_back(mk(65536, 46341, 0, 0));
      dir.push_back(mk(65536, 32768, 12345, 1));
      dir.push_back(mk(3, 656, 1, 1));
      dir.push_back(mk(4194304, 7000, 4194303, 0));
      dir.push_back(mk(1, 1, 1, 1));
      dir.push_back(mk(8388607, 131071, 8388607, 1));
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (dir[i]) send(dir[i]);
      for (k = 0; k < N_RAND; k++) begin
         if (k == 300) begin
            // drain fully before continuing
            req_valid <= 1'b0;
            @(posedge clock);
            while (pending_bias.size() != 0) @(posedge clock);
         end
         calm = (k >= 600 && k < 800);
         case ($urandom_range(9))
            0: r = mk($urandom, $urandom, $urandom, $urandom);
            1: r = mk($urandom_range(8388607), $urandom_range(700), $urandom_range(8388607),
                      $urandom);
            2: r = mk($urandom_range(8388607), $urandom_range(66000, 65000),
                      $urandom, $urandom);
            3: r = mk($urandom_range(255), $urandom_range(65536), $urandom_range(255),
                      $urandom);
            default: r = mk($urandom_range(8388607), $urandom_range(65536),
                            $urandom_range(8388607), $urandom);
         endcase
         send(r);
      end
      calm = 1'b0;
      req_valid <= 1'b0;
      while (pending_bias.size() != 0) @(posedge clock);
      repeat (LAT + 10) @(posedge clock);
      done = 1'b1;
      $display("%0d transfers sent (directed extremes and random), %0d results checked",
               sent, results_seen);
      if (mismatches == 0 && pending_bias.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/core/sbd_pkg.sv
rtl/core/shadow_bias_derivation.sv
sim/tb_top.sv
